// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the grid index.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/ugni_pkg.sv =====
`default_nettype none
package ugni_pkg;
	localparam int MAX_OBJECTS = 64;
	localparam int MAX_CELLS   = 1024;
	localparam int OBJ_W       = $clog2(MAX_OBJECTS);
	localparam int LINK_W      = OBJ_W + 1;
	localparam int CELL_W      = $clog2(MAX_CELLS);
	localparam int NB_W        = CELL_W + 2;
	localparam int CNT_W       = OBJ_W + 1;
	localparam int COORD_W     = 16;
	localparam int COLS_W      = 6;
	localparam int STEP_W      = $clog2(COORD_W);
	localparam int NB_COUNT    = 9;
	localparam int NBI_W       = $clog2(NB_COUNT + 1);

	localparam logic [LINK_W-1:0] EMPTY_LINK = {LINK_W{1'b1}};

	localparam logic [1:0] KIND_PLACE  = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_FIND   = 2'd2;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_ABSENT  = 2'd1;
	localparam logic [1:0] STAT_OUTSIDE = 2'd2;

	localparam logic CFG_BLOCK_SIZE  = 1'b0;
	localparam logic CFG_MAP_COLUMNS = 1'b1;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_RESP,
		S_DIV,
		S_DIV_DONE,
		S_UL_CELL,
		S_UL_HEAD,
		S_UL_WALK,
		S_UL_END,
		S_AP_RD,
		S_AP_WR,
		S_AP_WR2,
		S_F_CELL,
		S_F_SEL,
		S_F_HEAD,
		S_F_EMIT,
		S_F_NEXT,
		S_F_END
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/core/ugni_ram.sv =====
`default_nettype none
module ugni_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/core/uniform_grid_neighbor_index.sv =====
// Channel  | Handshake            | Beat
// ---------+----------------------+----------------------------------------
// in       | in_valid / in_stall  | kind, obj_id, pos_x, pos_y
// out      | out_valid / out_stall| found_id, has_id, last, status
// cfg      | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item at a time. Place divides the position by the block size, unlinks
// the object from its old cell list if present and appends it to the new one.
// Remove walks the old cell list to unlink the object. Find reads each neighbor
// cell and lists its objects; the walk goes through the shared object-link RAM.
// After reset a sweep empties all 1024 cells of the cell RAM; in_stall stays high.
// A full output register with out_stall high holds the walk.
`default_nettype none
`include "assert_macros.svh"
module uniform_grid_neighbor_index import ugni_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         kind,
	input  wire logic [OBJ_W-1:0]   obj_id,
	input  wire logic [COORD_W-1:0] pos_x,
	input  wire logic [COORD_W-1:0] pos_y,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [OBJ_W-1:0]        found_id,
	output logic                    has_id,
	output logic                    last,
	output logic [1:0]              status,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);
	state_t state_q, state_d;

	logic [COORD_W-1:0]     block_size_q;
	logic [COLS_W-1:0]      map_columns_q;
	logic [MAX_OBJECTS-1:0] present_q;
	logic [1:0]             kind_q;
	logic [OBJ_W-1:0]       id_q;
	logic [1:0]             status_q;
	logic [COORD_W-1:0]     dvd_a_q, dvd_b_q, rem_a_q, rem_b_q, divisor_q;
	logic [STEP_W-1:0]      cnt_q;
	logic [CELL_W-1:0]      cell_q, own_q, clr_q;
	logic [LINK_W-1:0]      head_q, tail_q, cur_q, prev_q;
	logic [NB_COUNT-1:0]    mask_q;
	logic [NBI_W-1:0]       cidx_q;
	logic                   pend_valid_q;
	logic [OBJ_W-1:0]       pend_id_q;
	logic [CNT_W-1:0]       n_q;
	logic                   out_valid_q, has_id_q, last_q;
	logic [OBJ_W-1:0]       found_id_q;
	logic [1:0]             status_out_q;

	logic                      cm_we;
	logic [CELL_W-1:0]         cm_waddr, cm_raddr;
	logic [2*LINK_W-1:0]       cm_wdata, cm_rdata;
	logic                      nx_we;
	logic [OBJ_W-1:0]          nx_waddr, nx_raddr;
	logic [LINK_W-1:0]         nx_wdata, nx_rdata;
	logic                      oc_we;
	logic [OBJ_W-1:0]          oc_raddr;
	logic [CELL_W-1:0]         oc_rdata;

	logic               push, push_has, push_last, can_push;
	logic [OBJ_W-1:0]   push_id;
	logic [1:0]         push_status;

	logic [COORD_W:0]   ta, tb, da, db;
	logic               ga, gb;
	logic [COORD_W-1:0] cols_ext;
	logic [NB_W-1:0]    prod_cell;
	logic               outside;
	logic               fr, fl, fu, fd;
	logic [NB_COUNT-1:0] flags, mask_d;
	logic [LINK_W-1:0]  id_link;

	function automatic logic [NB_W-1:0] nb_cell(input logic [CELL_W-1:0] own,
			input logic [COLS_W-1:0] cols, input logic [NBI_W-1:0] idx);
		logic [NB_W-1:0] o, c, r;
		o = NB_W'(own);
		c = NB_W'(cols);
		unique case (idx)
			NBI_W'(1): r = o + NB_W'(1);
			NBI_W'(2): r = o - NB_W'(1);
			NBI_W'(3): r = o - c;
			NBI_W'(4): r = o + c;
			NBI_W'(5): r = o - c + NB_W'(1);
			NBI_W'(6): r = o + c + NB_W'(1);
			NBI_W'(7): r = o - c - NB_W'(1);
			NBI_W'(8): r = o + c - NB_W'(1);
			default:   r = o;
		endcase
		return r;
	endfunction

	ugni_ram #(.WIDTH(2 * LINK_W), .DEPTH(MAX_CELLS)) u_cell_ram (
		.clk   (clk),
		.we    (cm_we),
		.waddr (cm_waddr),
		.wdata (cm_wdata),
		.raddr (cm_raddr),
		.rdata (cm_rdata)
	);

	ugni_ram #(.WIDTH(LINK_W), .DEPTH(MAX_OBJECTS)) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.raddr (nx_raddr),
		.rdata (nx_rdata)
	);

	ugni_ram #(.WIDTH(CELL_W), .DEPTH(MAX_OBJECTS)) u_objcell_ram (
		.clk   (clk),
		.we    (oc_we),
		.waddr (id_q),
		.wdata (cell_q),
		.raddr (oc_raddr),
		.rdata (oc_rdata)
	);

	assign cfg_ready = 1'b1;
	assign can_push  = !out_valid_q || !out_stall;
	assign id_link   = {1'b0, id_q};
	assign cols_ext  = COORD_W'(map_columns_q);

	assign ta = {rem_a_q, dvd_a_q[COORD_W-1]};
	assign tb = {rem_b_q, dvd_b_q[COORD_W-1]};
	assign ga = ta >= {1'b0, divisor_q};
	assign gb = tb >= {1'b0, divisor_q};
	assign da = ga ? ta - {1'b0, divisor_q} : ta;
	assign db = gb ? tb - {1'b0, divisor_q} : tb;

	assign prod_cell = NB_W'(dvd_a_q[COLS_W-1:0])
		+ NB_W'(dvd_b_q[COLS_W-1:0]) * NB_W'(map_columns_q);
	assign outside = dvd_a_q >= cols_ext || dvd_b_q >= cols_ext
		|| prod_cell >= NB_W'(MAX_CELLS);

	assign fr = ({1'b0, rem_a_q} + (COORD_W + 1)'(1)) < {1'b0, cols_ext};
	assign fl = rem_a_q != '0;
	assign fu = dvd_a_q != '0;
	assign fd = ({1'b0, dvd_a_q} + (COORD_W + 1)'(1)) < {1'b0, cols_ext};
	assign flags = {fl & fd, fl & fu, fr & fd, fr & fu, fd, fu, fl, fr, 1'b1};

	always_comb begin
		for (int i = 0; i < NB_COUNT; i++) begin
			mask_d[i] = flags[i]
				&& nb_cell(own_q, map_columns_q, NBI_W'(i)) < NB_W'(MAX_CELLS);
		end
	end

	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		push        = 1'b0;
		push_id     = '0;
		push_has    = 1'b0;
		push_last   = 1'b1;
		push_status = STAT_OK;
		cm_we       = 1'b0;
		cm_waddr    = own_q;
		cm_wdata    = {EMPTY_LINK, EMPTY_LINK};
		cm_raddr    = own_q;
		nx_we       = 1'b0;
		nx_waddr    = id_q;
		nx_wdata    = EMPTY_LINK;
		nx_raddr    = cur_q[OBJ_W-1:0];
		oc_we       = 1'b0;
		oc_raddr    = id_q;
		unique case (state_q)
			S_CLEAR: begin
				cm_we    = 1'b1;
				cm_waddr = clr_q;
				if (clr_q == CELL_W'(MAX_CELLS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				oc_raddr = obj_id;
				if (in_valid) begin
					priority case (kind)
						KIND_PLACE: begin
							if (block_size_q == '0 || map_columns_q == '0) begin
								state_d = S_RESP;
							end else begin
								state_d = S_DIV;
							end
						end
						KIND_REMOVE: state_d = present_q[obj_id] ? S_UL_CELL : S_RESP;
						KIND_FIND:   state_d = present_q[obj_id] ? S_F_CELL : S_RESP;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_RESP: begin
				if (can_push) begin
					push        = 1'b1;
					push_status = status_q;
					state_d     = S_IDLE;
				end
			end
			S_DIV: begin
				if (cnt_q == {STEP_W{1'b1}}) begin
					state_d = S_DIV_DONE;
				end
			end
			S_DIV_DONE: begin
				if (kind_q == KIND_FIND) begin
					state_d = S_F_SEL;
				end else if (outside) begin
					state_d = S_RESP;
				end else if (present_q[id_q]) begin
					state_d = S_UL_CELL;
				end else begin
					state_d = S_AP_RD;
				end
			end
			S_UL_CELL: begin
				cm_raddr = oc_rdata;
				state_d  = S_UL_HEAD;
			end
			S_UL_HEAD: begin
				nx_raddr = cm_rdata[2*LINK_W-2 -: OBJ_W];
				state_d  = cm_rdata[2*LINK_W-1] ? S_UL_END : S_UL_WALK;
			end
			S_UL_WALK: begin
				if (cur_q == id_link) begin
					cm_we    = 1'b1;
					cm_wdata = {(prev_q == EMPTY_LINK) ? nx_rdata : head_q,
						(tail_q == id_link) ? prev_q : tail_q};
					if (prev_q != EMPTY_LINK) begin
						nx_we    = 1'b1;
						nx_waddr = prev_q[OBJ_W-1:0];
						nx_wdata = nx_rdata;
					end
					state_d = S_UL_END;
				end else begin
					nx_raddr = nx_rdata[OBJ_W-1:0];
					if (nx_rdata[LINK_W-1]) begin
						state_d = S_UL_END;
					end
				end
			end
			S_UL_END: begin
				state_d = (kind_q == KIND_PLACE) ? S_AP_RD : S_RESP;
			end
			S_AP_RD: begin
				cm_raddr = cell_q;
				state_d  = S_AP_WR;
			end
			S_AP_WR: begin
				oc_we    = 1'b1;
				cm_we    = 1'b1;
				cm_waddr = cell_q;
				cm_wdata = {cm_rdata[LINK_W-1] ? id_link : cm_rdata[2*LINK_W-1:LINK_W],
					id_link};
				if (!cm_rdata[LINK_W-1]) begin
					nx_we    = 1'b1;
					nx_waddr = cm_rdata[OBJ_W-1:0];
					nx_wdata = id_link;
				end
				state_d = S_AP_WR2;
			end
			S_AP_WR2: begin
				nx_we   = 1'b1;
				state_d = S_RESP;
			end
			S_F_CELL: begin
				state_d = (map_columns_q == '0) ? S_F_SEL : S_DIV;
			end
			S_F_SEL: begin
				cm_raddr = nb_cell(own_q, map_columns_q, cidx_q)[CELL_W-1:0];
				if (cidx_q == NBI_W'(NB_COUNT)) begin
					state_d = S_F_END;
				end else if (mask_q[cidx_q]) begin
					state_d = S_F_HEAD;
				end
			end
			S_F_HEAD: begin
				state_d = cm_rdata[2*LINK_W-1] ? S_F_SEL : S_F_EMIT;
			end
			S_F_EMIT: begin
				if (n_q == CNT_W'(MAX_OBJECTS)) begin
					state_d = S_F_END;
				end else if (!pend_valid_q || can_push) begin
					push      = pend_valid_q;
					push_id   = pend_id_q;
					push_has  = 1'b1;
					push_last = 1'b0;
					state_d   = S_F_NEXT;
				end
			end
			S_F_NEXT: begin
				state_d = nx_rdata[LINK_W-1] ? S_F_SEL : S_F_EMIT;
			end
			S_F_END: begin
				if (can_push) begin
					push     = 1'b1;
					push_id  = pend_valid_q ? pend_id_q : '0;
					push_has = pend_valid_q;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			block_size_q  <= COORD_W'(100);
			map_columns_q <= COLS_W'(32);
			present_q     <= '0;
			pend_valid_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + CELL_W'(1);
			end
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_BLOCK_SIZE:  block_size_q  <= cfg_data;
					CFG_MAP_COLUMNS: map_columns_q <= cfg_data[COLS_W-1:0];
					default:         block_size_q  <= block_size_q;
				endcase
			end
			if (state_q == S_AP_WR2) begin
				present_q[id_q] <= 1'b1;
			end else if (state_q == S_UL_END && kind_q == KIND_REMOVE) begin
				present_q[id_q] <= 1'b0;
			end
			if (state_q == S_F_EMIT && state_d == S_F_NEXT) begin
				pend_valid_q <= 1'b1;
			end else if (state_q == S_F_END && can_push) begin
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			found_id_q   <= push_id;
			has_id_q     <= push_has;
			last_q       <= push_last;
			status_out_q <= push_status;
		end
		unique case (state_q)
			S_IDLE: begin
				kind_q    <= kind;
				id_q      <= obj_id;
				n_q       <= '0;
				cidx_q    <= '0;
				status_q  <= present_q[obj_id] ? STAT_OK : STAT_ABSENT;
				if (kind == KIND_PLACE) begin
					status_q <= STAT_OUTSIDE;
				end
				dvd_a_q   <= pos_x;
				dvd_b_q   <= pos_y;
				rem_a_q   <= '0;
				rem_b_q   <= '0;
				divisor_q <= block_size_q;
				cnt_q     <= '0;
			end
			S_DIV: begin
				rem_a_q <= da[COORD_W-1:0];
				rem_b_q <= db[COORD_W-1:0];
				dvd_a_q <= {dvd_a_q[COORD_W-2:0], ga};
				dvd_b_q <= {dvd_b_q[COORD_W-2:0], gb};
				cnt_q   <= cnt_q + STEP_W'(1);
			end
			S_DIV_DONE: begin
				cell_q <= prod_cell[CELL_W-1:0];
				mask_q <= mask_d;
			end
			S_UL_CELL: own_q <= oc_rdata;
			S_UL_HEAD: begin
				head_q <= cm_rdata[2*LINK_W-1:LINK_W];
				tail_q <= cm_rdata[LINK_W-1:0];
				cur_q  <= cm_rdata[2*LINK_W-1:LINK_W];
				prev_q <= EMPTY_LINK;
			end
			S_UL_WALK: begin
				prev_q <= cur_q;
				cur_q  <= nx_rdata;
			end
			S_UL_END: status_q <= STAT_OK;
			S_AP_WR2: status_q <= STAT_OK;
			S_F_CELL: begin
				own_q     <= oc_rdata;
				mask_q    <= NB_COUNT'(1);
				dvd_a_q   <= COORD_W'(oc_rdata);
				dvd_b_q   <= '0;
				rem_a_q   <= '0;
				rem_b_q   <= '0;
				divisor_q <= cols_ext;
				cnt_q     <= '0;
			end
			S_F_SEL: begin
				if (cidx_q != NBI_W'(NB_COUNT)) begin
					cidx_q <= cidx_q + NBI_W'(1);
				end
			end
			S_F_HEAD: cur_q <= cm_rdata[2*LINK_W-1:LINK_W];
			S_F_EMIT: begin
				if (state_d == S_F_NEXT) begin
					pend_id_q <= cur_q[OBJ_W-1:0];
					n_q       <= n_q + CNT_W'(1);
				end
			end
			S_F_NEXT: cur_q <= nx_rdata;
			default: cnt_q <= cnt_q;
		endcase
	end

	assign out_valid = out_valid_q;
	assign found_id  = found_id_q;
	assign has_id    = has_id_q;
	assign last      = last_q;
	assign status    = status_out_q;

	`ASSERT_CLK(a_last_ends_item, push && push_last |=> state_q == S_IDLE, "item did not end after last beat")
	`ASSERT_CLK(a_pend_in_find, pend_valid_q |-> (state_q == S_F_SEL || state_q == S_F_HEAD || state_q == S_F_EMIT || state_q == S_F_NEXT || state_q == S_F_END), "pending id outside find walk")
	`ASSERT_CLK(a_present_change, !$stable(present_q) |-> $past(state_q == S_AP_WR2 || state_q == S_UL_END), "presence changed outside place or remove")
	`ASSERT_ALWAYS(a_count_cap, n_q <= CNT_W'(MAX_OBJECTS) || state_q == S_IDLE || state_q == S_CLEAR, "find result count over cap")
endmodule
`default_nettype wire
